// ----- design/tcav_pkg.sv -----
// Shared types and constants for the tree common ancestor lookup block.
// Used by the RAM-side datapath, the controller and the top level; no dependencies.
package tcav_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int NODE_DEPTH = MAX_NODES + 1;
    localparam int NODE_W     = 11;
    localparam int TIP_W      = 10;
    localparam int SLOT_W     = 10;
    localparam int VALUE_W    = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [1:0] {
        OP_LINK  = 2'd0,
        OP_VALUE = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_TIP   = 2'd2,
        ST_RANGE = 2'd3
    } st_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIP_COUNT   = 1'd0,
        CFG_VALUE_COUNT = 1'd1
    } cfg_idx_t;

    typedef struct packed {
        op_t                opcode;
        logic [NODE_W-1:0]  link_child;
        logic [NODE_W-1:0]  link_parent;
        logic [SLOT_W-1:0]  value_slot;
        logic [VALUE_W-1:0] value_word;
        logic [TIP_W-1:0]   first_tip;
        logic [TIP_W-1:0]   second_tip;
    } tcav_in_t;

    typedef struct packed {
        st_t                status;
        logic [NODE_W-1:0]  ancestor_node;
        logic [VALUE_W-1:0] node_value;
    } tcav_out_t;

    // One datapath action per cycle, chosen by the controller
    typedef enum logic [2:0] {
        DP_NOP    = 3'd0,
        DP_CLEAR  = 3'd1,
        DP_LOAD   = 3'd2,
        DP_START  = 3'd3,
        DP_MARK   = 3'd4,
        DP_SEEK   = 3'd5,
        DP_SEARCH = 3'd6,
        DP_EVAL   = 3'd7
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t cmd;
        logic    unmark;
    } dp_ctl_t;

    typedef struct packed {
        logic entry_mark;
        logic parent_zero;
        logic step_last;
        logic clear_last;
    } dp_status_t;

endpackage

// ----- design/tree_common_ancestor_value_lookup.sv -----
// Top level of the tree common ancestor lookup block.
// Depends on tcav_pkg, tcav_ctrl and tcav_dp (which holds the tcav_ram instances).
//
// A word is taken at a clock edge with start high and busy low. Link and value
// loads give no result and leave busy low. After a query is taken, busy stays
// high through the mark walk up from the first tip, the seek step, the search
// walk up from the second tip (at most 1025 nodes visited), the eval step and
// the unmark walk. The mark walk stops at the chain end or at a node that is
// already marked; the unmark walk takes as many steps as the mark walk.
// The walks advance one node a cycle through the parent table's single read port.
// The result is registered in the eval step and is on result for the one cycle
// that done is high, while the unmark walk still runs; it cannot be held off and
// must be taken in that cycle. After reset, busy stays high while the parent
// table is cleared; configuration writes are taken during that time.
module tree_common_ancestor_value_lookup
    import tcav_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  tcav_in_t              item,
    output logic                  done,
    output tcav_out_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_ctl_t    ctl;
    dp_status_t stat;

    tcav_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (item.opcode),
        .stat   (stat),
        .ctl    (ctl),
        .busy   (busy),
        .done   (done)
    );

    tcav_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .stat     (stat),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule

// ----- design/tcav_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcav_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/tcav_dp.sv -----
// Datapath: parent/mark table, value table, walk pointer, config and result registers.
// Depends on tcav_pkg and tcav_ram.
module tcav_dp
    import tcav_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_ctl_t               ctl,
    output dp_status_t            stat,
    input  tcav_in_t              item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output tcav_out_t             result
);

    typedef struct packed {
        logic              mark;
        logic [NODE_W-1:0] parent;
    } entry_t;

    entry_t             prd;
    entry_t             eff;
    logic               pwe;
    logic [NODE_W-1:0]  pwaddr;
    entry_t             pwdata;
    logic [NODE_W-1:0]  praddr;
    logic               vwe;
    logic [SLOT_W-1:0]  vraddr;
    logic [VALUE_W-1:0] vrd;

    logic [NODE_W-1:0]  cur_reg, cur_next;
    logic [NODE_W-1:0]  a_reg, a_next;
    logic [NODE_W-1:0]  b_reg, b_next;
    logic [NODE_W-1:0]  steps_reg, steps_next;
    logic               found_reg, found_next;
    logic [NODE_W-1:0]  clr_reg, clr_next;
    logic               wr_v_reg;
    logic [NODE_W-1:0]  wr_addr_reg;
    entry_t             wr_data_reg;
    st_t                st_reg, st_next;
    logic [NODE_W-1:0]  anc_reg, anc_next;
    logic [NODE_W-1:0]  tip_reg, tip_next;
    logic [NODE_W-1:0]  vcnt_reg, vcnt_next;

    logic [NODE_W-1:0]  tip_a;
    logic [NODE_W-1:0]  tip_b;
    logic [NODE_W-1:0]  diff;
    logic               link_ok;

    tcav_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NODE_DEPTH)
    ) u_parent_ram (
        .clk   (clk),
        .we    (pwe),
        .waddr (pwaddr),
        .wdata (pwdata),
        .raddr (praddr),
        .rdata (prd)
    );

    tcav_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_NODES)
    ) u_value_ram (
        .clk   (clk),
        .we    (vwe),
        .waddr (item.value_slot),
        .wdata (item.value_word),
        .raddr (vraddr),
        .rdata (vrd)
    );

    // Forward last cycle's write when it hit the entry being read back now
    assign eff = (wr_v_reg && (wr_addr_reg == cur_reg)) ? wr_data_reg : prd;

    assign tip_a   = {1'b0, item.first_tip} + NODE_W'(1);
    assign tip_b   = {1'b0, item.second_tip} + NODE_W'(1);
    assign diff    = cur_reg - tip_reg - NODE_W'(1);
    assign vraddr  = diff[SLOT_W-1:0];
    assign link_ok = (item.link_child != '0)
                  && (item.link_child <= NODE_W'(MAX_NODES))
                  && (item.link_parent <= NODE_W'(MAX_NODES));

    assign stat.entry_mark  = eff.mark;
    assign stat.parent_zero = (eff.parent == '0);
    assign stat.step_last   = (steps_reg == NODE_W'(MAX_NODES));
    assign stat.clear_last  = (clr_reg == NODE_W'(MAX_NODES));

    always_comb
    begin
        cur_next   = cur_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        steps_next = steps_reg;
        found_next = found_reg;
        clr_next   = clr_reg;
        st_next    = st_reg;
        anc_next   = anc_reg;
        tip_next   = tip_reg;
        vcnt_next  = vcnt_reg;
        pwe        = 1'b0;
        pwaddr     = cur_reg;
        pwdata     = '0;
        praddr     = cur_reg;
        vwe        = 1'b0;

        if (ctl.unmark)
        begin
            // clear the mark and advance; stop is decided by the controller
            pwe      = eff.mark;
            pwdata   = '{mark: 1'b0, parent: eff.parent};
            cur_next = eff.parent;
            praddr   = eff.parent;
        end

        case (ctl.cmd)
            DP_CLEAR:
            begin
                pwe      = 1'b1;
                pwaddr   = clr_reg;
                pwdata   = '0;
                clr_next = clr_reg + NODE_W'(1);
            end
            DP_LOAD:
            begin
                case (item.opcode)
                    OP_LINK:
                    begin
                        pwe    = link_ok;
                        pwaddr = item.link_child;
                        pwdata = '{mark: 1'b0, parent: item.link_parent};
                    end
                    OP_VALUE:
                    begin
                        vwe = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            DP_START:
            begin
                a_next   = tip_a;
                b_next   = tip_b;
                cur_next = tip_a;
                praddr   = tip_a;
            end
            DP_MARK:
            begin
                pwe      = !eff.mark;
                pwdata   = '{mark: 1'b1, parent: eff.parent};
                cur_next = eff.parent;
                praddr   = eff.parent;
            end
            DP_SEEK:
            begin
                cur_next   = b_reg;
                praddr     = b_reg;
                steps_next = '0;
            end
            DP_SEARCH:
            begin
                found_next = eff.mark;
                // hold the pointer on the ancestor once found
                if (!eff.mark)
                begin
                    cur_next   = eff.parent;
                    praddr     = eff.parent;
                    steps_next = steps_reg + NODE_W'(1);
                end
            end
            DP_EVAL:
            begin
                anc_next = cur_reg;
                if (!found_reg)
                begin
                    st_next  = ST_NONE;
                    anc_next = '0;
                end
                else if (cur_reg <= tip_reg)
                begin
                    st_next = ST_TIP;
                end
                else if (diff >= vcnt_reg)
                begin
                    st_next = ST_RANGE;
                end
                else
                begin
                    st_next = ST_OK;
                end
                cur_next = a_reg;
                praddr   = a_reg;
            end
            default:
            begin
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_TIP_COUNT:   tip_next  = cfg_data;
                CFG_VALUE_COUNT: vcnt_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            wr_v_reg <= 1'b0;
            tip_reg  <= NODE_W'(1);
            vcnt_reg <= '0;
        end
        else
        begin
            clr_reg  <= clr_next;
            wr_v_reg <= pwe;
            tip_reg  <= tip_next;
            vcnt_reg <= vcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        steps_reg   <= steps_next;
        found_reg   <= found_next;
        st_reg      <= st_next;
        anc_reg     <= anc_next;
        wr_addr_reg <= pwaddr;
        wr_data_reg <= pwdata;
    end

    assign result.status        = st_reg;
    assign result.ancestor_node = anc_reg;
    assign result.node_value    = (st_reg == ST_OK) ? vrd : '0;

endmodule

// ----- design/tcav_ctrl.sv -----
// Controller: sequences table clearing, loads and the mark/search/unmark walks.
// Depends on tcav_pkg.
module tcav_ctrl
    import tcav_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  op_t        opcode,
    input  dp_status_t stat,
    output dp_ctl_t    ctl,
    output logic       busy,
    output logic       done
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK,
        S_SEEK,
        S_SEARCH,
        S_EVAL,
        S_UNMARK
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        ctl.cmd    = DP_NOP;
        ctl.unmark = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.cmd = DP_CLEAR;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_QUERY)
                    begin
                        ctl.cmd    = DP_START;
                        state_next = S_MARK;
                    end
                    else
                    begin
                        ctl.cmd = DP_LOAD;
                    end
                end
            end
            S_MARK:
            begin
                ctl.cmd = DP_MARK;
                if (stat.entry_mark || stat.parent_zero)
                begin
                    state_next = S_SEEK;
                end
            end
            S_SEEK:
            begin
                ctl.cmd    = DP_SEEK;
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                ctl.cmd = DP_SEARCH;
                if (stat.entry_mark || stat.step_last || stat.parent_zero)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                ctl.cmd    = DP_EVAL;
                done_next  = 1'b1;
                state_next = S_UNMARK;
            end
            S_UNMARK:
            begin
                ctl.unmark = 1'b1;
                // drop out at the chain end or at the node where marking stopped
                if (!stat.entry_mark || stat.parent_zero)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for tree_common_ancestor_value_lookup.
// Loads parent links and values, queries tip pairs and checks each answer.
// Depends on tcav_pkg and the block under test only.
module testbench
    import tcav_pkg::*;
;

    localparam int DRAIN_CYCLES = NODE_DEPTH + 75;
    localparam op_t OP_SPARE = op_t'(2'd3);
    localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES = {CFG_DATA_W{1'b1}};

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    tcav_in_t              item;
    logic                  done;
    tcav_out_t             result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the block's tables and registers
    logic [NODE_W-1:0]  parent_link [0:MAX_NODES];
    logic [VALUE_W-1:0] node_values [0:MAX_NODES-1];
    bit                 value_loaded [0:MAX_NODES-1];
    logic [CFG_DATA_W-1:0] tip_reg;
    logic [CFG_DATA_W-1:0] value_reg;

    tcav_out_t pending_answers [$];
    int errors;
    int words_sent;
    int answers;
    int settings;
    int status_seen [4];
    bit steady_flow;

    tree_common_ancestor_value_lookup DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(100_000_000);
        $display("testbench NOT OK");
        $finish;
    end

    // Mark the first tip's ancestors, then climb from the second tip to the first mark
    function automatic tcav_out_t find_common_ancestor(input int first, input int second,
                                                       output int missing_slot);
        bit        marked [0:MAX_NODES];
        int        cur;
        int        steps;
        int        slot;
        int        tips;
        int        vals;
        bit        found;
        tcav_out_t answer;
        marked = '{default: 1'b0};
        missing_slot = -1;
        tips = tip_reg;
        vals = value_reg;
        answer = '0;
        answer.status = ST_NONE;
        cur = first + 1;
        while (cur != 0 && cur <= MAX_NODES && !marked[cur])
        begin
            marked[cur] = 1'b1;
            cur = parent_link[cur];
        end
        cur = second + 1;
        found = 1'b0;
        for (steps = 0; steps <= MAX_NODES; steps++)
        begin
            if (marked[cur])
            begin
                found = 1'b1;
                break;
            end
            cur = parent_link[cur];
            if (cur == 0 || cur > MAX_NODES)
                break;
        end
        if (!found)
            return answer;
        answer.ancestor_node = NODE_W'(cur);
        if (cur <= tips)
        begin
            answer.status = ST_TIP;
            return answer;
        end
        slot = cur - tips - 1;
        if (slot >= vals || slot >= MAX_NODES)
        begin
            answer.status = ST_RANGE;
            return answer;
        end
        answer.status = ST_OK;
        if (!value_loaded[slot])
            missing_slot = slot;
        answer.node_value = node_values[slot];
        return answer;
    endfunction

    task automatic apply_word(input tcav_in_t w);
        int        missing;
        tcav_out_t expected;
        case (w.opcode)
            OP_LINK:
                if (w.link_child >= 1 && w.link_child <= MAX_NODES &&
                    w.link_parent <= MAX_NODES)
                    parent_link[w.link_child] = w.link_parent;
            OP_VALUE:
            begin
                node_values[w.value_slot] = w.value_word;
                value_loaded[w.value_slot] = 1'b1;
            end
            OP_QUERY:
            begin
                expected = find_common_ancestor(w.first_tip, w.second_tip, missing);
                pending_answers.insert(pending_answers.size(), expected);
            end
            default:
                ;
        endcase
    endtask

    function automatic tcav_in_t random_word();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[$bits(tcav_in_t)-1:0];
    endfunction

    // Hold start until the word is taken; update the shadow at that edge
    task automatic send_word(input tcav_in_t w);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_word(w);
        words_sent++;
    endtask

    task automatic link(input int child, input int up_node);
        tcav_in_t w;
        w = random_word();
        w.opcode = OP_LINK;
        w.link_child = NODE_W'(child);
        w.link_parent = NODE_W'(up_node);
        send_word(w);
    endtask

    task automatic load_value(input int slot, input logic [VALUE_W-1:0] word);
        tcav_in_t w;
        w = random_word();
        w.opcode = OP_VALUE;
        w.value_slot = SLOT_W'(slot);
        w.value_word = word;
        send_word(w);
    endtask

    // Fill the slot a query would read first if it was never loaded
    task automatic ask_pair(input int first, input int second);
        tcav_in_t  w;
        tcav_out_t unused_answer;
        int        missing;
        unused_answer = find_common_ancestor(first, second, missing);
        if (missing >= 0)
            load_value(missing, {$urandom, $urandom});
        w = random_word();
        w.opcode = OP_QUERY;
        w.first_tip = TIP_W'(first);
        w.second_tip = TIP_W'(second);
        send_word(w);
    endtask

    // Drop start, drain answers, then let the unmark walk finish
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input int tips, input int vals);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_TIP_COUNT;
        cfg_data <= CFG_DATA_W'(tips);
        @(posedge clk);
        tip_reg = CFG_DATA_W'(tips);
        cfg_addr <= CFG_VALUE_COUNT;
        cfg_data <= CFG_DATA_W'(vals);
        @(posedge clk);
        value_reg = CFG_DATA_W'(vals);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Link a node to a random higher internal node so the tree stays acyclic
    task automatic tree_link(input int node, input int tips, input int root);
        int lowest;
        lowest = (node + 1 > tips + 1) ? node + 1 : tips + 1;
        link(node, $urandom_range(lowest, root));
    endtask

    task automatic test_after_reset();
        ask_pair(0, 0);
        ask_pair(0, MAX_NODES - 1);
        send_word(random_word() | {OP_SPARE, {($bits(tcav_in_t) - 2){1'b0}}});
        link(0, 5);
        link(2047, 3);
        link(3, 2047);
        ask_pair(2, 0);
    endtask

    task automatic test_small_tree();
        wait_idle();
        set_config(4, 3);
        link(1, 5);
        link(2, 5);
        link(3, 6);
        link(4, 6);
        link(5, 7);
        link(6, 7);
        link(7, 0);
        load_value(0, {VALUE_W{1'b1}});
        load_value(1, '0);
        load_value(2, {$urandom, $urandom});
        ask_pair(0, 1);
        ask_pair(2, 3);
        ask_pair(0, 3);
        ask_pair(4, 0);
        // tip under tip: the ancestor itself is a tip
        link(1, 2);
        ask_pair(0, 1);
        link(1, 5);
        wait_idle();
        set_config(4, 2);
        ask_pair(1, 2);
    endtask

    task automatic test_cycles();
        link(8, 9);
        link(9, 8);
        ask_pair(7, 0);
        ask_pair(0, 7);
        ask_pair(7, 8);
        link(9, 0);
    endtask

    task automatic test_extreme_config();
        wait_idle();
        set_config(0, MAX_NODES);
        link(1, MAX_NODES);
        load_value(MAX_NODES - 1, {$urandom, $urandom});
        ask_pair(0, MAX_NODES - 1);
        ask_pair(0, 0);
        wait_idle();
        set_config(CFG_ALL_ONES, CFG_ALL_ONES);
        ask_pair(0, MAX_NODES - 1);
        wait_idle();
        set_config(MAX_NODES - 1, 1);
        ask_pair(MAX_NODES - 1, 0);
    endtask

    task automatic test_random_trees();
        int tips;
        int inner;
        int root;
        int pick;
        tcav_in_t w;
        logic [CFG_DATA_W-1:0] tip_set;
        logic [CFG_DATA_W-1:0] value_set;
        for (int phase = 0; phase < 8; phase++)
        begin
            tips = $urandom_range(2, 8);
            inner = $urandom_range(1, tips - 1);
            root = tips + inner;
            case (phase % 4)
                0: value_set = CFG_DATA_W'(inner);
                1: value_set = CFG_ALL_ONES;
                2: value_set = '0;
                default: value_set = CFG_DATA_W'($urandom_range(0, inner));
            endcase
            tip_set = (phase == 2) ? CFG_ALL_ONES : (phase == 5) ? '0 : CFG_DATA_W'(tips);
            wait_idle();
            set_config(tip_set, value_set);
            steady_flow = (phase % 3 == 1);
            for (int node = 1; node < root; node++)
                tree_link(node, tips, root);
            link(root, 0);
            repeat (13)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    ask_pair($urandom_range(0, root - 1), $urandom_range(0, root - 1));
                else if (pick < 75)
                    tree_link($urandom_range(1, root - 1), tips, root);
                else if (pick < 82)
                    load_value($urandom_range(0, inner), {$urandom, $urandom});
                else
                begin
                    w = random_word();
                    if (w.opcode == OP_QUERY)
                        ask_pair(w.first_tip, w.second_tip);
                    else
                        send_word(w);
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin : check_answers
        tcav_out_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: answer with none pending: status %0d node %0d value %h",
                         $time, result.status, result.ancestor_node, result.node_value);
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                answers++;
                status_seen[want.status]++;
                if (result.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, result.status);
                    errors++;
                end
                if (result.ancestor_node !== want.ancestor_node)
                begin
                    $display("%0t: ancestor_node expected %0d got %0d",
                             $time, want.ancestor_node, result.ancestor_node);
                    errors++;
                end
                if (result.node_value !== want.node_value)
                begin
                    $display("%0t: node_value expected %h got %h",
                             $time, want.node_value, result.node_value);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        item <= '0;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_data <= '0;
        for (int n = 0; n <= MAX_NODES; n++)
            parent_link[n] = '0;
        for (int n = 0; n < MAX_NODES; n++)
        begin
            node_values[n] = '0;
            value_loaded[n] = 1'b0;
        end
        tip_reg = 1;
        value_reg = 0;
        steady_flow = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_small_tree();
        test_cycles();
        test_extreme_config();
        test_random_trees();
        wait_idle();

        $display("Run: %0d words, %0d register settings, %0d answers checked",
                 words_sent, settings, answers);
        $display("Answers by status: ok %0d, no ancestor %0d, tip %0d, out of range %0d",
                 status_seen[ST_OK], status_seen[ST_NONE], status_seen[ST_TIP],
                 status_seen[ST_RANGE]);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
design/tcav_pkg.sv
design/tcav_ram.sv
design/tcav_dp.sv
design/tcav_ctrl.sv
design/tree_common_ancestor_value_lookup.sv
bench/testbench.sv
